>>> rtl/tpc_pkg.sv
// ============================================================================
// tpc_pkg - three point path curvature package
// Shared types and constants for the curvature core.
// ============================================================================
`default_nettype none

package tpc_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int CURV_FRAC_BITS_DEF = 16;
    localparam int COORD_FRAC_BITS    = 16;
    localparam int CURV_W             = 23;
    localparam int MIN_W              = 16;
    localparam int CFG_AW             = 3;

    localparam logic [MIN_W-1:0]  MIN_SIDE_RST = 16'd1311;
    localparam logic [CURV_W-1:0] DEGEN_RST    = 23'd6553600;

    localparam logic REG_MIN_SIDE = 1'b0;
    localparam logic REG_DEGEN    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SIDE,
        ST_AB,
        ST_ABC,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_ROOT,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/three_point_path_curvature_core.sv
// ============================================================================
// three_point_path_curvature_core - Menger curvature of sliding point triples
// Side lengths, Heron product and quotient are formed by one bit-serial
// multiplier, one two-bits-per-cycle square root unit and a restoring divider.
// ============================================================================
//
//  channel  | direction | fields (low bit first)
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | tdata: point_x, point_y; tlast: final_point
//  m_*      | out       | tdata: curvature; tlast: run_end; tuser: path_empty
//  APB      | config    | 0x0 min_side_length, 0x4 degenerate_curvature
//
// A point that completes a triple runs the serial multiplier (squares of the
// side offsets, then a*b, abc and the three Heron factors), the square root
// unit (each side, then the Heron product) and the restoring divider.
// A degenerate triple ends after the three sides.
// Other points fill the window or end the path; results wait for output requests.
// Reset is synchronous and clears the path state; no input is taken while
// results are pending or a triple is being evaluated.
`default_nettype none

module three_point_path_curvature_core #(
    parameter int COORD_WIDTH    = tpc_pkg::COORD_WIDTH_DEF,
    parameter int CURV_FRAC_BITS = tpc_pkg::CURV_FRAC_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, zero fill
    input  wire  [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // curvature, zero fill
    output logic [23:0]                         m_tdata,
    output logic                                m_tlast,
    // path_empty
    output logic                                m_tuser,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [tpc_pkg::CFG_AW-1:0]          paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW   = COORD_WIDTH;
    localparam int SW   = CW + 1;
    localparam int MBW  = SW + 2;
    localparam int MAW  = 3*SW + 4;
    localparam int PW   = MAW + MBW;
    localparam int RW   = PW / 2;
    localparam int ABCW = 3*SW;
    localparam int QW   = tpc_pkg::CURV_W + 1;
    localparam int NUMW = RW + CURV_FRAC_BITS + tpc_pkg::COORD_FRAC_BITS;
    localparam int DW   = (ABCW + QW > NUMW) ? ABCW + QW : NUMW;
    localparam int CNTW = $clog2(RW);
    localparam int CV   = tpc_pkg::CURV_W;

    tpc_pkg::t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic [1:0]      r_side, r_pts, r_left;
    logic            r_head, r_fin, r_empty;
    logic [tpc_pkg::MIN_W-1:0] r_min;
    logic [CV-1:0]   r_degen, r_k;

    logic signed [CW-1:0] r_wx0, r_wx1, r_wy0, r_wy1, r_px, r_py;
    logic [2*SW:0]   r_sqx;
    logic [SW-1:0]   r_sa, r_sb, r_sc;
    logic [ABCW-1:0] r_abc;
    logic [MAW-1:0]  r_ma;
    logic [MBW-1:0]  r_mb;
    logic [PW-1:0]   r_acc;
    logic [PW-1:0]   r_rad;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [DW-1:0]   r_dr, r_dd;
    logic [QW-1:0]   r_q;

    logic            in_acc, out_acc, cfg_wr;
    logic            mul_last, sq_last, dv_last, degen;
    logic [MAW:0]    mul_sum;
    logic [PW-1:0]   mul_next;
    logic [RW+3:0]   rem_sh, trial, rem_diff;
    logic            sq_ge;
    logic [RW+1:0]   rem_next;
    logic [RW-1:0]   root_next;
    logic            dv_ge;
    logic [QW-1:0]   q_next;
    logic [CV-1:0]   q_curv;
    logic [1:0]      sel_side;
    logic signed [CW-1:0] ux, vx, uy, vy;
    logic signed [SW-1:0] dxs, dys;
    logic [SW-1:0]   dx, dy, side_new;
    logic [MBW-1:0]  ea, eb, ec, s1, f1, f2, f3;
    logic [2*SW:0]   sq_sum;
    logic signed [CW-1:0] in_x, in_y;

    assign in_x   = s_tdata[CW-1:0];
    assign in_y   = s_tdata[2*CW-1:CW];
    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;
    assign cfg_wr  = psel & penable & pwrite & pready;

    assign mul_last = (r_cnt == CNTW'(MBW - 1));
    assign sq_last  = (r_cnt == CNTW'(RW - 1));
    assign dv_last  = (r_cnt == CNTW'(QW - 1));

    // Serial multiplier: one multiplier bit per cycle, product builds from the top.
    assign mul_sum  = {1'b0, r_acc[PW-1:MBW]} + (r_mb[0] ? {1'b0, r_ma} : '0);
    assign mul_next = {mul_sum, r_acc[MBW-1:1]};

    // Restoring square root: two radicand bits per cycle.
    assign rem_sh    = {r_rem, r_rad[PW-1:PW-2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign rem_diff  = rem_sh - trial;
    assign sq_ge     = (rem_sh >= trial);
    assign rem_next  = sq_ge ? rem_diff[RW+1:0] : rem_sh[RW+1:0];
    assign root_next = {r_root[RW-2:0], sq_ge};
    assign side_new  = root_next[SW-1:0];

    // Restoring divider: one quotient bit per cycle, top bit means saturation.
    assign dv_ge  = (r_dr >= r_dd);
    assign q_next = {r_q[QW-2:0], dv_ge};
    assign q_curv = q_next[QW-1] ? '1 : q_next[CV-1:0];

    assign sel_side = (r_state == tpc_pkg::ST_SIDE) ? r_side + 2'd1 : r_side;

    always_comb begin
        case (sel_side)
            2'd0: begin
                ux = r_wx1; vx = r_wx0; uy = r_wy1; vy = r_wy0;
            end
            2'd1: begin
                ux = r_px;  vx = r_wx1; uy = r_py;  vy = r_wy1;
            end
            default: begin
                ux = r_px;  vx = r_wx0; uy = r_py;  vy = r_wy0;
            end
        endcase
    end

    assign dxs = SW'(ux) - SW'(vx);
    assign dys = SW'(uy) - SW'(vy);
    assign dx  = dxs[SW-1] ? SW'(-dxs) : SW'(dxs);
    assign dy  = dys[SW-1] ? SW'(-dys) : SW'(dys);

    assign sq_sum = r_sqx + (2*SW+1)'(mul_next);

    assign degen = (r_sa <= SW'(r_min)) || (r_sb <= SW'(r_min))
                || (side_new <= SW'(r_min));

    assign ea = MBW'(r_sa);
    assign eb = MBW'(r_sb);
    assign ec = MBW'(r_sc);
    assign s1 = ea + eb + ec;
    assign f1 = (eb + ec >= ea) ? eb + ec - ea : ea - eb - ec;
    assign f2 = (ea + ec >= eb) ? ea + ec - eb : eb - ea - ec;
    assign f3 = (ea + eb >= ec) ? ea + eb - ec : ec - ea - eb;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tpc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (r_pts == 2'd2) begin
                        n_state = tpc_pkg::ST_SQX;
                    end else if (s_tlast) begin
                        n_state = tpc_pkg::ST_EMIT;
                    end
                end
            end
            tpc_pkg::ST_SQX: if (mul_last) n_state = tpc_pkg::ST_SQY;
            tpc_pkg::ST_SQY: if (mul_last) n_state = tpc_pkg::ST_SIDE;
            tpc_pkg::ST_SIDE: begin
                if (sq_last) begin
                    if (r_side != 2'd2) begin
                        n_state = tpc_pkg::ST_SQX;
                    end else if (degen) begin
                        n_state = tpc_pkg::ST_EMIT;
                    end else begin
                        n_state = tpc_pkg::ST_AB;
                    end
                end
            end
            tpc_pkg::ST_AB:   if (mul_last) n_state = tpc_pkg::ST_ABC;
            tpc_pkg::ST_ABC:  if (mul_last) n_state = tpc_pkg::ST_H1;
            tpc_pkg::ST_H1:   if (mul_last) n_state = tpc_pkg::ST_H2;
            tpc_pkg::ST_H2:   if (mul_last) n_state = tpc_pkg::ST_H3;
            tpc_pkg::ST_H3:   if (mul_last) n_state = tpc_pkg::ST_ROOT;
            tpc_pkg::ST_ROOT: if (sq_last) n_state = tpc_pkg::ST_DIV;
            tpc_pkg::ST_DIV:  if (dv_last) n_state = tpc_pkg::ST_EMIT;
            tpc_pkg::ST_EMIT: begin
                if (out_acc && r_left == 2'd1) n_state = tpc_pkg::ST_IDLE;
            end
            default: n_state = tpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (r_state == tpc_pkg::ST_IDLE);
        m_tvalid = (r_state == tpc_pkg::ST_EMIT);
        m_tdata  = {1'b0, r_k};
        m_tlast  = r_fin && (r_left == 2'd1);
        m_tuser  = r_empty;
        pready   = 1'b1;
        prdata   = (paddr[2] == tpc_pkg::REG_DEGEN) ? 32'(r_degen) : 32'(r_min);
    end

    // A triple finishes when the divider ends or the sides prove degenerate.
    logic finish;
    assign finish = (r_state == tpc_pkg::ST_DIV && dv_last)
                 || (r_state == tpc_pkg::ST_SIDE && sq_last && r_side == 2'd2 && degen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpc_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_side  <= 2'd0;
            r_pts   <= 2'd0;
            r_head  <= 1'b1;
            r_left  <= 2'd0;
            r_min   <= tpc_pkg::MIN_SIDE_RST;
            r_degen <= tpc_pkg::DEGEN_RST;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
            if (cfg_wr) begin
                if (paddr[2] == tpc_pkg::REG_MIN_SIDE) begin
                    r_min <= pwdata[tpc_pkg::MIN_W-1:0];
                end else begin
                    r_degen <= pwdata[CV-1:0];
                end
            end
            if (r_state == tpc_pkg::ST_IDLE && in_acc && r_pts != 2'd2) begin
                if (s_tlast) begin
                    r_pts  <= 2'd0;
                    r_head <= 1'b1;
                    r_left <= 2'd1;
                end else begin
                    r_pts <= r_pts + 2'd1;
                end
            end
            if (r_state == tpc_pkg::ST_SIDE && sq_last) begin
                r_side <= (r_side == 2'd2) ? 2'd0 : r_side + 2'd1;
            end
            if (finish) begin
                r_left <= 2'd1 + {1'b0, r_head} + {1'b0, r_fin};
                r_head <= r_fin;
                if (r_fin) r_pts <= 2'd0;
            end
            if (out_acc) r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tpc_pkg::ST_IDLE: begin
                r_acc <= '0;
                r_ma  <= MAW'(dx);
                r_mb  <= MBW'(dx);
                if (in_acc) begin
                    r_fin <= s_tlast;
                    r_px  <= in_x;
                    r_py  <= in_y;
                    if (r_pts != 2'd2) begin
                        if (s_tlast) begin
                            r_k     <= '0;
                            r_empty <= 1'b1;
                        end else begin
                            r_wx0 <= r_wx1;
                            r_wy0 <= r_wy1;
                            r_wx1 <= in_x;
                            r_wy1 <= in_y;
                        end
                    end
                end
            end
            tpc_pkg::ST_SQX: begin
                r_acc <= mul_next;
                r_mb  <= r_mb >> 1;
                if (mul_last) begin
                    r_sqx <= (2*SW+1)'(mul_next);
                    r_acc <= '0;
                    r_ma  <= MAW'(dy);
                    r_mb  <= MBW'(dy);
                end
            end
            tpc_pkg::ST_SQY: begin
                r_acc <= mul_next;
                r_mb  <= r_mb >> 1;
                if (mul_last) begin
                    r_rad  <= PW'(sq_sum);
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            tpc_pkg::ST_SIDE, tpc_pkg::ST_ROOT: begin
                r_rem  <= rem_next;
                r_root <= root_next;
                r_rad  <= r_rad << 2;
                if (sq_last && r_state == tpc_pkg::ST_SIDE) begin
                    case (r_side)
                        2'd0:    r_sa <= side_new;
                        2'd1:    r_sb <= side_new;
                        default: r_sc <= side_new;
                    endcase
                    r_acc <= '0;
                    if (r_side == 2'd2) begin
                        r_ma <= MAW'(r_sa);
                        r_mb <= MBW'(r_sb);
                    end else begin
                        r_ma <= MAW'(dx);
                        r_mb <= MBW'(dx);
                    end
                end
                if (sq_last && r_state == tpc_pkg::ST_ROOT) begin
                    r_dr <= DW'({root_next, {(NUMW-RW){1'b0}}});
                    r_dd <= DW'({r_abc, {(QW-1){1'b0}}});
                    r_q  <= '0;
                end
            end
            tpc_pkg::ST_AB, tpc_pkg::ST_ABC, tpc_pkg::ST_H1, tpc_pkg::ST_H2,
            tpc_pkg::ST_H3: begin
                r_acc <= mul_next;
                r_mb  <= r_mb >> 1;
                if (mul_last) begin
                    r_acc <= '0;
                    r_ma  <= mul_next[MAW-1:0];
                    case (r_state)
                        tpc_pkg::ST_AB:  r_mb <= MBW'(r_sc);
                        tpc_pkg::ST_ABC: begin
                            r_abc <= mul_next[ABCW-1:0];
                            r_ma  <= MAW'(s1);
                            r_mb  <= f1;
                        end
                        tpc_pkg::ST_H1:  r_mb <= f2;
                        tpc_pkg::ST_H2:  r_mb <= f3;
                        default: begin
                            r_rad  <= mul_next;
                            r_rem  <= '0;
                            r_root <= '0;
                        end
                    endcase
                end
            end
            tpc_pkg::ST_DIV: begin
                r_q  <= q_next;
                r_dr <= dv_ge ? r_dr - r_dd : r_dr;
                r_dd <= r_dd >> 1;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (finish) begin
            r_empty <= 1'b0;
            r_k     <= (r_state == tpc_pkg::ST_DIV) ? q_curv : r_degen;
            if (!r_fin) begin
                r_wx0 <= r_wx1;
                r_wy0 <= r_wy1;
                r_wx1 <= r_px;
                r_wy1 <= r_py;
            end
        end
    end

`ifndef SYNTH
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while results pending");
    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 24'd0))
        else $error("empty path result malformed");
    a_pts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pts != 2'd3)
        else $error("point count out of range");
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> r_left != 2'd0)
        else $error("result shown with none pending");
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_left == 2'd1) |=> s_tready)
        else $error("block not idle after last result");
`endif

endmodule

`default_nettype wire
